[hw/rtl/dwa_pkg.sv]
// shared types and constants for the depth warp anaglyph row block
package dwa_pkg;

    localparam int COL_W   = 10;
    localparam int COLOR_W = 8;
    localparam int DEPTH_W = 16;
    localparam int SCALE_W = 24;
    localparam int WIDTH_W = 10;
    localparam int CMD_W   = 2;
    localparam int PIX_W   = 2 * COLOR_W;

    localparam int MAX_WIDTH_DEF = 640;
    localparam int FRAC_BITS_DEF = 4;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd420000;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 10'd640;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [0:0] {
        REG_SCALE = 1'b0,
        REG_WIDTH = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_DIV   = 2'd2,
        ST_READ  = 2'd3
    } state_t;

endpackage

[hw/rtl/dwa_if.sv]
// valid/ready channel interfaces for pixel commands and anaglyph results
interface dwa_in_if;
    import dwa_pkg::*;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [COL_W-1:0]   column;
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;
    logic [DEPTH_W-1:0] depth_mm;

    modport source (output valid, cmd, column, red_in, green_in, blue_in, depth_mm,
                    input ready);
    modport sink (input valid, cmd, column, red_in, green_in, blue_in, depth_mm,
                  output ready);
endinterface

interface dwa_out_if;
    import dwa_pkg::*;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] red_out;
    logic [COLOR_W-1:0] green_out;
    logic [COLOR_W-1:0] blue_out;
    logic               hole;

    modport source (output valid, red_out, green_out, blue_out, hole, input ready);
    modport sink (input valid, red_out, green_out, blue_out, hole, output ready);
endinterface

[hw/rtl/dwa_ram.sv]
// generic single-write, single-read ram with registered read data
module dwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 640
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[hw/rtl/dwa_div.sv]
// restoring divider, one quotient bit per cycle
module dwa_div #(
    parameter int DVD_W = 24,
    parameter int DVS_W = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quot,
    output logic [DVS_W-1:0] rem
);
    localparam int CNT_W = $clog2(DVD_W);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quot_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             fits;

    assign shifted = {rem_reg, quot_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = !diff[DVS_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (run_reg)
        begin
            quot_reg <= {quot_reg[DVD_W-2:0], fits};
            rem_reg  <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;
endmodule

[hw/rtl/depth_warp_anaglyph_row.sv]
// top level: per-row forward depth warp with red/cyan anaglyph readout
//
//  channel   dir  words                      handshake
//  in_ch     in   cmd/column/rgb/depth_mm    valid & ready
//  out_ch    out  red/green/blue/hole        valid & ready
//  cfg       in   cfg_index/cfg_data         cfg_we, no back-pressure
//
// load with nonzero depth waits in the divide state until the bit-serial divider is done
// load with zero depth, or a load or read outside the row, finishes in the idle state
// read goes through the registered ram port and the read state into the output register
// start row marks all MAX_WIDTH warp entries as holes, one per cycle, before the next word
// after reset a sweep clears both rams; input is held off meanwhile
// a finished result waits in the output register; the next word is held off until it is taken
module depth_warp_anaglyph_row #(
    parameter int MAX_WIDTH = dwa_pkg::MAX_WIDTH_DEF,
    parameter int FRAC_BITS = dwa_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [0:0]                   cfg_index,
    input  logic [dwa_pkg::SCALE_W-1:0]  cfg_data,
    dwa_in_if.sink                       in_ch,
    dwa_out_if.source                    out_ch
);
    import dwa_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int DVS_W = DEPTH_W + FRAC_BITS;
    localparam int CMP_W = ($clog2(MAX_WIDTH + 1) > COL_W) ? $clog2(MAX_WIDTH + 1) : COL_W;
    localparam int WRP_W = PIX_W + 1;

    state_t state_reg, state_next;

    logic [SCALE_W-1:0] scale_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic               clr_red_reg;
    logic [COL_W-1:0]   col_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [DVS_W-1:0]   den_reg;

    logic               out_valid_reg;
    logic [COLOR_W-1:0] red_out_reg;
    logic [COLOR_W-1:0] green_out_reg;
    logic [COLOR_W-1:0] blue_out_reg;
    logic               hole_out_reg;

    logic [CMP_W-1:0]   width_eff;
    logic               accept;
    logic               in_row;
    cmd_t               cmd;

    logic               div_start;
    logic               div_done;
    logic [SCALE_W-1:0] quot;
    logic [DVS_W-1:0]   rem;
    logic [DVS_W-1:0]   den_in;

    logic               red_we;
    logic [AW-1:0]      red_waddr;
    logic [COLOR_W-1:0] red_wdata;
    logic [COLOR_W-1:0] red_rdata;
    logic               wrp_we;
    logic [AW-1:0]      wrp_waddr;
    logic [WRP_W-1:0]   wrp_wdata;
    logic [WRP_W-1:0]   wrp_rdata;
    logic [AW-1:0]      raddr;

    logic               col_gt;
    logic               col_eq;
    logic               rem_zero;
    logic               round_down;
    logic               half_below;
    logic [SCALE_W-1:0] tgt_full;
    logic [CMP_W-1:0]   tgt;
    logic               keep;
    logic               read_done;
    logic               start_clear;

    // effective width saturates at the ram depth
    assign width_eff = (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH)
                                                                 : CMP_W'(width_reg);

    assign in_ch.ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ch.ready);
    assign accept      = in_ch.valid && in_ch.ready;
    assign cmd         = cmd_t'(in_ch.cmd);
    assign in_row      = CMP_W'(in_ch.column) < width_eff;
    assign raddr       = AW'(in_ch.column);
    assign den_in      = DVS_W'(in_ch.depth_mm) << FRAC_BITS;

    // target = column - q - round_down, with q and r from scale / (depth << frac)
    assign col_gt     = SCALE_W'(col_reg) > quot;
    assign col_eq     = SCALE_W'(col_reg) == quot;
    assign rem_zero   = rem == '0;
    assign round_down = {rem, 1'b0} > {1'b0, den_reg};
    assign half_below = {rem, 1'b0} < {1'b0, den_reg};
    assign tgt_full   = SCALE_W'(col_reg) - quot - SCALE_W'(round_down);
    assign tgt        = CMP_W'(tgt_full);
    assign keep       = ((col_gt || (col_eq && rem_zero)) && (tgt < width_eff))
                        || (col_eq && half_below);

    always_comb
    begin
        state_next  = state_reg;
        div_start   = 1'b0;
        read_done   = 1'b0;
        start_clear = 1'b0;
        red_we      = 1'b0;
        red_waddr   = AW'(in_ch.column);
        red_wdata   = in_ch.red_in;
        wrp_we      = 1'b0;
        wrp_waddr   = AW'(in_ch.column);
        wrp_wdata   = {1'b0, in_ch.green_in, in_ch.blue_in};
        unique case (state_reg)
            ST_CLEAR:
            begin
                red_we    = clr_red_reg;
                red_waddr = clr_cnt_reg;
                red_wdata = '0;
                wrp_we    = 1'b1;
                wrp_waddr = clr_cnt_reg;
                wrp_wdata = {1'b1, {PIX_W{1'b0}}};
                if (clr_cnt_reg == AW'(MAX_WIDTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_START:
                        begin
                            start_clear = 1'b1;
                            state_next  = ST_CLEAR;
                        end
                        CMD_LOAD:
                        begin
                            if (in_row)
                            begin
                                red_we = 1'b1;
                                if (in_ch.depth_mm == '0)
                                begin
                                    wrp_we = 1'b1;
                                end
                                else
                                begin
                                    div_start  = 1'b1;
                                    state_next = ST_DIV;
                                end
                            end
                        end
                        CMD_READ:
                        begin
                            if (in_row)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                wrp_waddr = AW'(tgt);
                wrp_wdata = {1'b0, pix_reg};
                if (div_done)
                begin
                    wrp_we     = keep;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                read_done  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            clr_red_reg <= 1'b1;
            scale_reg   <= SCALE_RESET;
            width_reg   <= WIDTH_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                if (clr_cnt_reg == AW'(MAX_WIDTH - 1))
                begin
                    clr_cnt_reg <= '0;
                    clr_red_reg <= 1'b0;
                end
                else
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
            end
            if (start_clear)
            begin
                clr_red_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_SCALE: scale_reg <= cfg_data;
                    REG_WIDTH: width_reg <= cfg_data[WIDTH_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            col_reg <= in_ch.column;
            pix_reg <= {in_ch.green_in, in_ch.blue_in};
            den_reg <= den_in;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (read_done || (accept && (cmd == CMD_READ) && !in_row))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (read_done)
        begin
            red_out_reg   <= red_rdata;
            hole_out_reg  <= wrp_rdata[PIX_W];
            green_out_reg <= wrp_rdata[PIX_W] ? '0 : wrp_rdata[PIX_W-1:COLOR_W];
            blue_out_reg  <= wrp_rdata[PIX_W] ? '0 : wrp_rdata[COLOR_W-1:0];
        end
        else if (accept && (cmd == CMD_READ) && !in_row)
        begin
            red_out_reg   <= '0;
            green_out_reg <= '0;
            blue_out_reg  <= '0;
            hole_out_reg  <= 1'b1;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.red_out   = red_out_reg;
    assign out_ch.green_out = green_out_reg;
    assign out_ch.blue_out  = blue_out_reg;
    assign out_ch.hole      = hole_out_reg;

    dwa_div #(
        .DVD_W (SCALE_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scale_reg),
        .divisor  (den_in),
        .done     (div_done),
        .quot     (quot),
        .rem      (rem)
    );

    dwa_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MAX_WIDTH)
    ) u_red_ram (
        .clk   (clk),
        .we    (red_we),
        .waddr (red_waddr),
        .wdata (red_wdata),
        .raddr (raddr),
        .rdata (red_rdata)
    );

    // hole mark in the top bit, green and blue below
    dwa_ram #(
        .WIDTH (WRP_W),
        .DEPTH (MAX_WIDTH)
    ) u_warp_ram (
        .clk   (clk),
        .we    (wrp_we),
        .waddr (wrp_waddr),
        .wdata (wrp_wdata),
        .raddr (raddr),
        .rdata (wrp_rdata)
    );

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_no_input_while_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ch.ready)
        else $error("input taken during clearing sweep");

    a_read_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> out_ch.valid)
        else $error("read finished without a result word");

endmodule

[test/dwa_tb_pkg.sv]
`timescale 1ns / 100ps
// word and result types used by the anaglyph row testbench
package dwa_tb_pkg;
    import dwa_pkg::*;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               hole;
    } anaglyph_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [COL_W-1:0]   column;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [DEPTH_W-1:0] depth;
    } pixel_word_t;

endpackage

[test/depth_warp_anaglyph_row_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the per-row depth warp anaglyph block
module depth_warp_anaglyph_row_tb;
    import dwa_pkg::*;
    import dwa_tb_pkg::*;

    localparam int ROW_MAX = MAX_WIDTH_DEF;
    localparam int FRAC = FRAC_BITS_DEF;
    // command code the block ignores
    localparam cmd_t CMD_SPARE = cmd_t'(2'd3);

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [SCALE_W-1:0] cfg_data;

    dwa_in_if in_ch ();
    dwa_out_if out_ch ();

    depth_warp_anaglyph_row DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
    );

    // predictor state
    logic [SCALE_W-1:0] scale_q;
    logic [WIDTH_W-1:0] width_q;
    logic [PIX_W-1:0]   view_row [ROW_MAX];
    logic               hole_row [ROW_MAX];
    logic [COLOR_W-1:0] red_row  [ROW_MAX];

    anaglyph_t pending_reads[$];
    int errors;
    int words_sent;
    int reads_seen;
    int holes_seen;
    bit hold_sink;
    bit sink_idle_on;
    bit src_idle_on;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("timeout at %0t", $time);
        $display("** depth_warp_anaglyph_row: FAILED **");
        $finish;
    end

    function automatic int eff_width();
        return (width_q > ROW_MAX) ? ROW_MAX : int'(width_q);
    endfunction

    // returns -1 when the warped pixel falls outside the row
    function automatic int warp_column(int col, int depth, int wd);
        longint den;
        longint num;
        longint t;
        den = longint'(depth) << FRAC;
        num = longint'(col) * den - longint'(scale_q);
        if (num >= 0)
        begin
            t = (2 * num + den) / (2 * den);
            return (t >= wd) ? -1 : int'(t);
        end
        if (2 * (-num) < den && wd != 0)
            return 0;
        return -1;
    endfunction

    task automatic predict_word(input pixel_word_t w);
        int wd;
        int tgt;
        anaglyph_t r;
        wd = eff_width();
        case (w.cmd)
            CMD_START:
                for (int i = 0; i < ROW_MAX; i++)
                    hole_row[i] = 1'b1;
            CMD_LOAD:
                if (int'(w.column) < wd)
                begin
                    red_row[w.column] = w.red;
                    tgt = (w.depth == '0) ? int'(w.column)
                                          : warp_column(int'(w.column), int'(w.depth), wd);
                    if (tgt >= 0)
                    begin
                        view_row[tgt] = {w.green, w.blue};
                        hole_row[tgt] = 1'b0;
                    end
                end
            CMD_READ:
            begin
                r = '0;
                r.hole = 1'b1;
                if (int'(w.column) < wd)
                begin
                    r.red = red_row[w.column];
                    if (!hole_row[w.column])
                    begin
                        r.green = view_row[w.column][PIX_W-1:COLOR_W];
                        r.blue = view_row[w.column][COLOR_W-1:0];
                        r.hole = 1'b0;
                    end
                end
                pending_reads.push_back(r);
            end
            default: ;
        endcase
    endtask

    // sender: one word per accepted handshake, with random gaps
    task automatic send_word(input pixel_word_t w);
        while (src_idle_on && $urandom_range(99) < 24)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= w.cmd;
        in_ch.column <= w.column;
        in_ch.red_in <= w.red;
        in_ch.green_in <= w.green;
        in_ch.blue_in <= w.blue;
        in_ch.depth_mm <= w.depth;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_word(w);
        words_sent++;
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [SCALE_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SCALE)
            scale_q = val;
        else
            width_q = val[WIDTH_W-1:0];
        @(posedge clk);
    endtask

    // wait until every read has come back and a start sweep can finish
    task automatic drain();
        int n;
        in_ch.valid <= 1'b0;
        n = 0;
        while (pending_reads.size() != 0 && n < 200_000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (ROW_MAX + 40) @(posedge clk);
    endtask

    function automatic pixel_word_t pw(cmd_t c, int col, int rd, int gr, int bl, int dp);
        pixel_word_t w;
        w.cmd = c;
        w.column = COL_W'(col);
        w.red = COLOR_W'(rd);
        w.green = COLOR_W'(gr);
        w.blue = COLOR_W'(bl);
        w.depth = DEPTH_W'(dp);
        return w;
    endfunction

    function automatic anaglyph_t ana(int rd, int gr, int bl, bit hl);
        anaglyph_t r;
        r.red = COLOR_W'(rd);
        r.green = COLOR_W'(gr);
        r.blue = COLOR_W'(bl);
        r.hole = hl;
        return r;
    endfunction

    function automatic pixel_word_t rand_word(int wd, bit rowish);
        pixel_word_t w;
        int sel;
        w.red = COLOR_W'($urandom);
        w.green = COLOR_W'($urandom);
        w.blue = COLOR_W'($urandom);
        sel = $urandom_range(99);
        if (sel < 4)
            w.cmd = CMD_SPARE;
        else if (sel < 6)
            w.cmd = CMD_START;
        else if (sel < 60)
            w.cmd = CMD_LOAD;
        else
            w.cmd = CMD_READ;
        if (rowish && wd > 0 && $urandom_range(9) != 0)
            w.column = COL_W'($urandom_range(wd - 1));
        else
            w.column = COL_W'($urandom);
        case ($urandom_range(5))
            0: w.depth = '0;
            1: w.depth = DEPTH_W'($urandom);
            2: w.depth = DEPTH_W'($urandom_range(200, 5000));
            default: w.depth = DEPTH_W'($urandom_range(1000, 60000));
        endcase
        return w;
    endfunction

    // sink: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_sink)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !(sink_idle_on && $urandom_range(99) < 24);
    end

    always @(posedge clk)
    begin
        anaglyph_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_reads.size() == 0)
            begin
                $display("%0t: result with nothing expected: %h %h %h %b", $time,
                         out_ch.red_out, out_ch.green_out, out_ch.blue_out, out_ch.hole);
                errors++;
            end
            else
            begin
                exp_r = pending_reads.pop_front();
                reads_seen++;
                if (out_ch.hole)
                    holes_seen++;
                if (out_ch.red_out !== exp_r.red)
                begin
                    $display("%0t: red expected %h actual %h", $time, exp_r.red,
                             out_ch.red_out);
                    errors++;
                end
                if (out_ch.green_out !== exp_r.green)
                begin
                    $display("%0t: green expected %h actual %h", $time, exp_r.green,
                             out_ch.green_out);
                    errors++;
                end
                if (out_ch.blue_out !== exp_r.blue)
                begin
                    $display("%0t: blue expected %h actual %h", $time, exp_r.blue,
                             out_ch.blue_out);
                    errors++;
                end
                if (out_ch.hole !== exp_r.hole)
                begin
                    $display("%0t: hole expected %b actual %b", $time, exp_r.hole,
                             out_ch.hole);
                    errors++;
                end
            end
        end
    end

    // directed words; all go through the predictor, and typed-in known results are checked against it
    typedef struct {
        pixel_word_t w;
        bit          known;
        anaglyph_t   r;
    } dir_row_t;

    dir_row_t dir_tab[$];

    function automatic dir_row_t mk(cmd_t c, int col, int rd, int gr, int bl, int dp,
                                    bit k = 1'b0, anaglyph_t r = '0);
        dir_row_t d;
        d.w = pw(c, col, rd, gr, bl, dp);
        d.known = k;
        d.r = r;
        return d;
    endfunction

    initial
    begin
        pixel_word_t w;
        int wd;
        int n_rand;
        int fails;
        errors = 0;
        words_sent = 0;
        reads_seen = 0;
        holes_seen = 0;
        hold_sink = 1'b0;
        sink_idle_on = 1'b1;
        src_idle_on = 1'b1;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SCALE;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_START;
        in_ch.column = '0;
        in_ch.red_in = '0;
        in_ch.green_in = '0;
        in_ch.blue_in = '0;
        in_ch.depth_mm = '0;
        out_ch.ready = 1'b0;
        scale_q = SCALE_RESET;
        width_q = WIDTH_RESET;
        for (int i = 0; i < ROW_MAX; i++)
        begin
            view_row[i] = '0;
            hole_row[i] = 1'b1;
            red_row[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_tab.push_back(mk(CMD_READ, 0, 0, 0, 0, 0, 1'b1, ana(0, 0, 0, 1'b1)));
        dir_tab.push_back(mk(CMD_READ, 639, 0, 0, 0, 0, 1'b1, ana(0, 0, 0, 1'b1)));
        dir_tab.push_back(mk(CMD_READ, 1023, 0, 0, 0, 0, 1'b1, ana(0, 0, 0, 1'b1)));
        dir_tab.push_back(mk(CMD_LOAD, 5, 255, 255, 255, 0));
        dir_tab.push_back(mk(CMD_READ, 5, 0, 0, 0, 0, 1'b1, ana(255, 255, 255, 1'b0)));
        dir_tab.push_back(mk(CMD_LOAD, 639, 170, 85, 170, 65535));
        dir_tab.push_back(mk(CMD_LOAD, 100, 1, 2, 3, 1));
        dir_tab.push_back(mk(CMD_LOAD, 300, 7, 8, 9, 1000));
        dir_tab.push_back(mk(CMD_LOAD, 301, 10, 11, 12, 1000));
        dir_tab.push_back(mk(CMD_LOAD, 0, 4, 5, 6, 65535));
        dir_tab.push_back(mk(CMD_LOAD, 640, 9, 9, 9, 0));
        dir_tab.push_back(mk(CMD_SPARE, 5, 0, 0, 0, 0));
        dir_tab.push_back(mk(CMD_READ, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(CMD_READ, 100, 0, 0, 0, 0));
        dir_tab.push_back(mk(CMD_READ, 274, 0, 0, 0, 0));
        dir_tab.push_back(mk(CMD_READ, 275, 0, 0, 0, 0));
        dir_tab.push_back(mk(CMD_READ, 612, 0, 0, 0, 0));
        dir_tab.push_back(mk(CMD_READ, 639, 0, 0, 0, 0));
        dir_tab.push_back(mk(CMD_READ, 640, 0, 0, 0, 0, 1'b1, ana(0, 0, 0, 1'b1)));
        dir_tab.push_back(mk(CMD_START, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(CMD_READ, 5, 0, 0, 0, 0, 1'b1, ana(255, 0, 0, 1'b1)));

        foreach (dir_tab[i])
        begin
            send_word(dir_tab[i].w);
            if (dir_tab[i].known && pending_reads[$] != dir_tab[i].r)
            begin
                $display("%0t: directed row %0d expected %h predicted %h", $time, i,
                         dir_tab[i].r, pending_reads[$]);
                errors++;
            end
        end
        drain();

        // small scale: a target of exactly -0.5 is dropped, and 0.5 rounds up to column 1
        write_reg(REG_SCALE, 24'd8);
        send_word(pw(CMD_LOAD, 0, 1, 0, 0, 1));
        send_word(pw(CMD_LOAD, 1, 1, 10, 20, 1));
        send_word(pw(CMD_READ, 0, 0, 0, 0, 0));
        send_word(pw(CMD_READ, 1, 0, 0, 0, 0));
        drain();

        // width zero leaves no columns at all
        write_reg(REG_WIDTH, 24'd0);
        send_word(pw(CMD_LOAD, 0, 9, 9, 9, 0));
        send_word(pw(CMD_READ, 0, 0, 0, 0, 0));
        drain();
        write_reg(REG_WIDTH, 24'd1023);
        write_reg(REG_SCALE, 24'hFFFFFF);
        send_word(pw(CMD_LOAD, 639, 1, 2, 3, 1));
        send_word(pw(CMD_READ, 639, 0, 0, 0, 0));
        drain();

        // random phases across several register settings
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_SCALE, SCALE_RESET); write_reg(REG_WIDTH, 24'd640); end
                1: begin write_reg(REG_SCALE, 24'd0); write_reg(REG_WIDTH, 24'd1); end
                2: begin write_reg(REG_SCALE, SCALE_W'($urandom));
                          write_reg(REG_WIDTH, 24'd37); end
                3: begin write_reg(REG_SCALE, 24'd50_000); write_reg(REG_WIDTH, 24'd64); end
                4: begin write_reg(REG_SCALE, SCALE_W'($urandom_range(2_000_000)));
                          write_reg(REG_WIDTH, SCALE_W'($urandom_range(1, 1023))); end
                default: begin write_reg(REG_SCALE, SCALE_RESET);
                               write_reg(REG_WIDTH, 24'd16); end
            endcase
            wd = eff_width();
            sink_idle_on = (ph != 3);
            src_idle_on = (ph != 3);
            n_rand = 0;
            while (n_rand < 180)
            begin
                w = rand_word(wd, 1'b1);
                if (ph == 2 && n_rand == 60)
                    fork
                        begin
                            hold_sink = 1'b1;
                            repeat (600) @(posedge clk);
                            hold_sink = 1'b0;
                        end
                    join_none
                send_word(w);
                if (w.cmd != CMD_SPARE)
                    n_rand++;
            end
            drain();
        end

        sink_idle_on = 1'b0;
        drain();
        fails = errors + pending_reads.size();
        $display("sent %0d words, checked %0d anaglyph reads (%0d holes)", words_sent,
                 reads_seen, holes_seen);
        $display("covered row widths 0 to 1023, scales 0 to max, zero and far depths");
        if (fails == 0)
            $display("** depth_warp_anaglyph_row: PASSED **");
        else
            $display("** depth_warp_anaglyph_row: FAILED **");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/dwa_pkg.sv
hw/rtl/dwa_if.sv
hw/rtl/dwa_ram.sv
hw/rtl/dwa_div.sv
hw/rtl/depth_warp_anaglyph_row.sv
test/dwa_tb_pkg.sv
test/depth_warp_anaglyph_row_tb.sv
